// File: rtl/core/id3fw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3fw_pkg
// Types and constants shared by the ID3v2 frame walker and its channels.
// ----------------------------------------------------------------------------
package id3fw_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CntW    = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CntW-1:0] TagHdrLen = CntW'(10);
  localparam logic [CntW-1:0] IdLen     = CntW'(4);
  localparam logic [CntW-1:0] SizeLen   = CntW'(4);
  localparam logic [CntW-1:0] FlagLen   = CntW'(2);

  localparam logic [CfgIdxW-1:0] CFG_MODE   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_TARGET = CfgIdxW'(1);

  localparam logic MODE_SHOW = 1'b0;
  localparam logic MODE_GET  = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_ID      = 3'd1,
    PH_SIZE    = 3'd2,
    PH_FLAGS   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

endpackage
`default_nettype wire

// File: rtl/core/id3fw_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3fw_in_if
// Byte channel into the frame walker: one file byte per transaction.
// ----------------------------------------------------------------------------
interface id3fw_in_if
  import id3fw_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             first;

  modport source (output valid, output in_byte, output first, input ready);
  modport sink   (input valid, input in_byte, input first, output ready);
endinterface
`default_nettype wire

// File: rtl/core/id3fw_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3fw_out_if
// Result channel of the frame walker: header, payload byte or end of walk.
// ----------------------------------------------------------------------------
interface id3fw_out_if
  import id3fw_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [WordW-1:0] frame_id;
  logic [WordW-1:0] frame_size;
  logic [ByteW-1:0] out_byte;
  logic             last;

  modport source (output valid, output kind, output frame_id, output frame_size,
                  output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input frame_id, input frame_size,
                  input out_byte, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/id3v2_frame_walker.sv
// A result is registered and appears in the output register the cycle after its byte.
// Throughput: one byte per cycle while results are taken; the state update is a
// counter step, one 32-bit decrement and one 32-bit id compare between the state
// and result regs. Input ready drops only while a result sits in the output
// register untaken. Reset (rst_ni low, asynchronous) clears the walk state, mode
// and target id and empties the output register.
`default_nettype none
// ----------------------------------------------------------------------------
// id3v2_frame_walker
// Skips the tag header and walks ID3v2 frames, reporting headers and payload.
// ----------------------------------------------------------------------------
module id3v2_frame_walker
  import id3fw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [WordW-1:0]   cfg_wdata_i,
  id3fw_in_if.sink                in_if,
  id3fw_out_if.source             out_if
);

  logic             mode_q;
  logic [WordW-1:0] target_q;

  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] id_q, id_d;
  logic [WordW-1:0] size_q, size_d;
  logic [WordW-1:0] rem_q, rem_d;
  logic             matched_q, matched_d;

  logic             ovalid_q;
  kind_e            kind_q, kind_d;
  logic [WordW-1:0] oid_q, oid_d;
  logic [WordW-1:0] osize_q, osize_d;
  logic [ByteW-1:0] obyte_q, obyte_d;
  logic             olast_q, olast_d;
  logic             emit;

  logic             accept;
  phase_e           ph_cur;
  logic [CntW-1:0]  cnt_cur;
  logic [CntW-1:0]  cnt_inc;
  logic             match_cur;
  logic [WordW-1:0] rem_dec;
  logic             hdr_match;
  logic [ByteW-1:0] b;

  assign in_if.ready = !ovalid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign b           = in_if.in_byte;

  assign ph_cur    = in_if.first ? PH_HEADER : phase_q;
  assign cnt_cur   = in_if.first ? '0 : cnt_q;
  assign match_cur = in_if.first ? 1'b0 : matched_q;
  assign cnt_inc   = cnt_cur + CntW'(1);
  assign rem_dec   = rem_q - WordW'(1);
  assign hdr_match = (mode_q == MODE_SHOW) || (id_q == target_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SHOW;
      target_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MODE) begin
        mode_q <= cfg_wdata_i[0];
      end else if (cfg_idx_i == CFG_TARGET) begin
        target_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    phase_d   = ph_cur;
    cnt_d     = cnt_cur;
    id_d      = id_q;
    size_d    = size_q;
    rem_d     = rem_q;
    matched_d = match_cur;

    case (ph_cur)
      PH_HEADER: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= TagHdrLen) begin
          phase_d = PH_ID;
          cnt_d   = '0;
        end
      end
      PH_ID: begin
        if (cnt_cur == '0 && b == '0) begin
          phase_d = PH_DONE;
        end else begin
          id_d  = {id_q[WordW-ByteW-1:0], b};
          cnt_d = cnt_inc;
          if (cnt_inc >= IdLen) begin
            phase_d = PH_SIZE;
            cnt_d   = '0;
          end
        end
      end
      PH_SIZE: begin
        size_d = {size_q[WordW-ByteW-1:0], b};
        cnt_d  = cnt_inc;
        if (cnt_inc >= SizeLen) begin
          phase_d = PH_FLAGS;
          cnt_d   = '0;
        end
      end
      PH_FLAGS: begin
        if (cnt_inc < FlagLen) begin
          cnt_d = cnt_inc;
        end else begin
          cnt_d     = '0;
          rem_d     = size_q;
          matched_d = hdr_match;
          if (!hdr_match) begin
            phase_d = (size_q == '0) ? PH_ID : PH_PAYLOAD;
          end else begin
            if (size_q == '0) begin
              phase_d   = (mode_q == MODE_GET) ? PH_DONE : PH_ID;
              matched_d = 1'b0;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        rem_d = rem_dec;
        if (!match_cur) begin
          if (rem_dec == '0) begin
            phase_d = PH_ID;
            cnt_d   = '0;
          end
        end else begin
          if (rem_dec == '0) begin
            phase_d   = (mode_q == MODE_GET) ? PH_DONE : PH_ID;
            cnt_d     = '0;
            matched_d = 1'b0;
          end
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
  end

  always_comb begin
    emit    = 1'b0;
    kind_d  = KIND_END;
    oid_d   = '0;
    osize_d = '0;
    obyte_d = '0;
    olast_d = 1'b0;

    case (ph_cur)
      PH_ID: begin
        if (cnt_cur == '0 && b == '0) begin
          emit   = 1'b1;
          kind_d = KIND_END;
        end
      end
      PH_FLAGS: begin
        if (cnt_inc >= FlagLen && hdr_match) begin
          emit    = 1'b1;
          kind_d  = KIND_HDR;
          oid_d   = id_q;
          osize_d = size_q;
          olast_d = (size_q == '0);
        end
      end
      PH_PAYLOAD: begin
        if (match_cur) begin
          emit    = 1'b1;
          kind_d  = KIND_DATA;
          oid_d   = id_q;
          osize_d = size_q;
          obyte_d = b;
          olast_d = (rem_dec == '0);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      cnt_q     <= '0;
      id_q      <= '0;
      size_q    <= '0;
      rem_q     <= '0;
      matched_q <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      id_q      <= id_d;
      size_q    <= size_d;
      rem_q     <= rem_d;
      matched_q <= matched_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (accept) begin
      ovalid_q <= emit;
    end else if (out_if.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q  <= kind_d;
      oid_q   <= oid_d;
      osize_q <= osize_d;
      obyte_q <= obyte_d;
      olast_q <= olast_d;
    end
  end

  assign out_if.valid      = ovalid_q;
  assign out_if.kind       = kind_q;
  assign out_if.frame_id   = oid_q;
  assign out_if.frame_size = osize_q;
  assign out_if.out_byte   = obyte_q;
  assign out_if.last       = olast_q;

`ifndef SYNTH
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_if.first && phase_q == PH_DONE) |=> !ovalid_q)
    else $error("result after walk finished");

  a_end_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && kind_q == KIND_END) |-> phase_q == PH_DONE)
    else $error("end transaction while walk still active");

  a_last_leaves_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && kind_q == KIND_DATA && olast_q) |-> phase_q != PH_PAYLOAD)
    else $error("frame still in payload after its last byte");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q < TagHdrLen) &&
    ((phase_q != PH_ID && phase_q != PH_SIZE) || cnt_q < IdLen) &&
    (phase_q != PH_FLAGS || cnt_q < FlagLen))
    else $error("field counter out of range");
`endif

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds tagged byte files through the ID3v2 frame walker in show and get
// modes: clean files, truncated ones and raw noise, with random stalls on
// both channels. Every header, payload byte and end marker is predicted
// and checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import id3fw_pkg::*;

  localparam int unsigned TagBytes   = 10;
  localparam int unsigned IdBytes    = 4;
  localparam int unsigned SizeBytes  = 4;
  localparam int unsigned FlagBytes  = 2;
  localparam int unsigned HeadBytes  = IdBytes + SizeBytes + FlagBytes;
  localparam int unsigned DrainWait  = 4;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned PhaseBytes = 250;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned MaxPrints  = 20;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = CfgIdxW'(3);

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_style_e;
  typedef enum logic {TX_STEADY, TX_BURSTY} tx_style_e;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             first;
  } file_byte_t;

  typedef struct packed {
    kind_e            kind;
    logic [WordW-1:0] fid;
    logic [WordW-1:0] fsize;
    logic [ByteW-1:0] ob;
    logic             last;
  } walk_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [WordW-1:0]   cfg_wdata;

  id3fw_in_if  byte_ch ();
  id3fw_out_if res_ch ();

  id3v2_frame_walker u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (byte_ch),
    .out_if      (res_ch)
  );

  // walk state as predicted
  phase_e           w_phase;
  logic [CntW-1:0]  w_cnt;
  logic [WordW-1:0] w_id;
  logic [WordW-1:0] w_size;
  logic [WordW-1:0] w_left;
  logic             w_matched;
  logic             w_finished;
  logic             cfg_mode;
  logic [WordW-1:0] cfg_target;

  file_byte_t   byte_q[$];
  walk_result_t results_due[$];
  logic [WordW-1:0] id_pool[4];

  logic        byte_taken   = 1'b0;
  logic        result_taken = 1'b0;
  int unsigned idle_cycles  = 0;
  int unsigned gap_left     = 0;
  int unsigned burst_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned rx_tick      = 0;
  rx_style_e   rx_style     = RX_ALWAYS;
  tx_style_e   tx_style     = TX_STEADY;

  int unsigned n_errors    = 0;
  int unsigned n_bytes     = 0;
  int unsigned n_files     = 0;
  int unsigned n_writes    = 0;
  int unsigned n_hdr       = 0;
  int unsigned n_data      = 0;
  int unsigned n_end       = 0;
  int unsigned phase_bytes = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    if (n_errors < MaxPrints) begin
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    end
    n_errors++;
  endtask

  task automatic walk_restart();
    w_phase    = PH_HEADER;
    w_cnt      = '0;
    w_id       = '0;
    w_size     = '0;
    w_left     = '0;
    w_matched  = 1'b0;
    w_finished = 1'b0;
  endtask

  task automatic note_result(input kind_e k, input logic [WordW-1:0] fid,
                             input logic [WordW-1:0] fsize, input logic [ByteW-1:0] ob,
                             input logic last);
    results_due.push_back('{kind: k, fid: fid, fsize: fsize, ob: ob, last: last});
  endtask

  task automatic frame_done();
    if (w_matched && cfg_mode == MODE_GET) begin
      w_finished = 1'b1;
      w_phase    = PH_DONE;
    end else begin
      w_phase = PH_ID;
    end
    w_cnt     = '0;
    w_matched = 1'b0;
  endtask

  task automatic walk_byte(input logic [ByteW-1:0] b, input logic restart);
    if (restart) walk_restart();
    if (w_finished || w_phase == PH_DONE) return;
    case (w_phase)
      PH_HEADER: begin
        w_cnt++;
        if (w_cnt >= TagBytes) begin
          w_phase = PH_ID;
          w_cnt   = '0;
        end
      end
      PH_ID: begin
        if (w_cnt == '0 && b == '0) begin
          w_finished = 1'b1;
          w_phase    = PH_DONE;
          note_result(KIND_END, '0, '0, '0, 1'b0);
        end else begin
          w_id = {w_id[WordW-ByteW-1:0], b};
          w_cnt++;
          if (w_cnt >= IdBytes) begin
            w_phase = PH_SIZE;
            w_cnt   = '0;
          end
        end
      end
      PH_SIZE: begin
        w_size = {w_size[WordW-ByteW-1:0], b};
        w_cnt++;
        if (w_cnt >= SizeBytes) begin
          w_phase = PH_FLAGS;
          w_cnt   = '0;
        end
      end
      PH_FLAGS: begin
        w_cnt++;
        if (w_cnt >= FlagBytes) begin
          w_cnt     = '0;
          w_left    = w_size;
          w_matched = (cfg_mode == MODE_SHOW) || (w_id == cfg_target);
          if (!w_matched) begin
            w_phase = (w_left == '0) ? PH_ID : PH_PAYLOAD;
          end else begin
            note_result(KIND_HDR, w_id, w_size, '0, w_left == '0);
            if (w_left == '0) frame_done();
            else w_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        w_left = w_left - 1'b1;
        if (!w_matched) begin
          if (w_left == '0) begin
            w_phase = PH_ID;
            w_cnt   = '0;
          end
        end else begin
          note_result(KIND_DATA, w_id, w_size, b, w_left == '0);
          if (w_left == '0) frame_done();
        end
      end
      default: ;
    endcase
  endtask

  // ---- stimulus helpers ----
  task automatic push_byte(input logic [ByteW-1:0] b, input logic first);
    byte_q.push_back({b, first});
    phase_bytes++;
  endtask

  task automatic push_tag_header();
    push_byte(ByteW'($urandom), 1'b1);
    repeat (TagBytes - 1) push_byte(ByteW'($urandom), 1'b0);
    n_files++;
  endtask

  // pushes the first nbytes of a frame header
  task automatic push_frame_head(input logic [WordW-1:0] id, input logic [WordW-1:0] size,
                                 input int unsigned nbytes);
    for (int i = 0; i < HeadBytes && i < nbytes; i++) begin
      if (i < IdBytes) push_byte(id[WordW-1-8*i -: 8], 1'b0);
      else if (i < IdBytes + SizeBytes) push_byte(size[WordW-1-8*(i-IdBytes) -: 8], 1'b0);
      else push_byte(ByteW'($urandom), 1'b0);
    end
  endtask

  task automatic push_frame(input logic [WordW-1:0] id, input logic [WordW-1:0] size,
                            input int unsigned npay);
    push_frame_head(id, size, HeadBytes);
    repeat (npay) push_byte(ByteW'($urandom), 1'b0);
  endtask

  function automatic logic [WordW-1:0] pick_id();
    if ($urandom_range(0, 1)) return id_pool[$urandom_range(0, 3)];
    return {ByteW'($urandom_range(1, 255)), 24'($urandom)};
  endfunction

  function automatic logic [WordW-1:0] pick_size();
    if ($urandom_range(0, 9) == 0) return WordW'($urandom_range(7, 40));
    return WordW'($urandom_range(0, 6));
  endfunction

  task automatic push_clean_file();
    logic [WordW-1:0] sz;
    push_tag_header();
    repeat ($urandom_range(0, 5)) begin
      sz = pick_size();
      push_frame(pick_id(), sz, sz);
    end
    push_byte('0, 1'b0);
    repeat ($urandom_range(0, 3)) push_byte(ByteW'($urandom), 1'b0);
  endtask

  // file cut off inside a frame header or inside a huge payload
  task automatic push_broken_file();
    logic [WordW-1:0] sz;
    int unsigned cut;
    push_tag_header();
    repeat ($urandom_range(0, 3)) begin
      sz = pick_size();
      push_frame(pick_id(), sz, sz);
    end
    cut = $urandom_range(1, HeadBytes);
    push_frame_head(pick_id(), $urandom, cut);
    if (cut == HeadBytes) repeat ($urandom_range(0, 5)) push_byte(ByteW'($urandom), 1'b0);
  endtask

  task automatic push_noise();
    repeat ($urandom_range(3, 16)) push_byte(ByteW'($urandom), $urandom_range(0, 7) == 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WordW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_MODE:   cfg_mode   = data[0];
      CFG_TARGET: cfg_target = data;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || byte_ch.valid || results_due.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (DrainWait) @(posedge clk);
  endtask

  // ---- driver ----
  always @(negedge clk) begin : driver
    file_byte_t nxt;
    logic       offer;
    if (rst_n && (!byte_ch.valid || byte_taken)) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (byte_q.size() > 0) begin
        nxt = byte_q.pop_front();
        byte_ch.in_byte <= nxt.b;
        byte_ch.first   <= nxt.first;
        offer = 1'b1;
        if (tx_style == TX_BURSTY) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end
      end
      byte_ch.valid <= offer;
    end
  end

  // ---- result sink ----
  always @(negedge clk) begin : receiver
    if (rst_n) begin
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS:   res_ch.ready <= 1'b1;
          RX_COIN:     res_ch.ready <= $urandom_range(0, 1) != 0;
          RX_PERIODIC: res_ch.ready <= (rx_tick % 7) > 2;
          default:     res_ch.ready <= $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin : monitor
    walk_result_t want;
    byte_taken   = rst_n && byte_ch.valid && byte_ch.ready;
    result_taken = rst_n && res_ch.valid && res_ch.ready;
    if (result_taken) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing due, kind", WordW'(res_ch.kind), '0);
      end else begin
        want = results_due.pop_front();
        if (res_ch.kind !== want.kind) begin
          report_mismatch("kind", WordW'(res_ch.kind), WordW'(want.kind));
        end
        if (res_ch.frame_id !== want.fid) report_mismatch("frame_id", res_ch.frame_id, want.fid);
        if (res_ch.frame_size !== want.fsize) begin
          report_mismatch("frame_size", res_ch.frame_size, want.fsize);
        end
        if (res_ch.out_byte !== want.ob) begin
          report_mismatch("out_byte", WordW'(res_ch.out_byte), WordW'(want.ob));
        end
        if (res_ch.last !== want.last) begin
          report_mismatch("last", WordW'(res_ch.last), WordW'(want.last));
        end
        case (want.kind)
          KIND_HDR:  n_hdr++;
          KIND_DATA: n_data++;
          default:   n_end++;
        endcase
      end
    end
    if (byte_taken) begin
      walk_byte(byte_ch.in_byte, byte_ch.first);
      n_bytes++;
    end
    idle_cycles = (byte_taken || result_taken) ? 0 : idle_cycles + 1;
  end

  always @(negedge clk) begin : watchdog
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transaction for %0d cycles, %0d results due",
               StallLimit, results_due.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---- sequence ----
  initial begin : stimulus
    logic             m;
    logic [WordW-1:0] t;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    byte_ch.first   = 1'b0;
    res_ch.ready    = 1'b0;
    walk_restart();
    cfg_mode   = MODE_SHOW;
    cfg_target = '0;
    id_pool[0] = {ByteW'($urandom_range(1, 255)), 24'($urandom)};
    id_pool[1] = {ByteW'($urandom_range(1, 255)), 24'($urandom)};
    id_pool[2] = 32'h0100_0000;
    id_pool[3] = '1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: empty frame, tiny frame, huge frame cut by a restart,
    // file with no frames, byte after the end
    push_tag_header();
    push_frame('1, '0, 0);
    push_frame(32'h0100_0000, 32'd1, 1);
    push_frame(32'h4249_4721, '1, 2);
    push_tag_header();
    push_byte('0, 1'b0);
    push_byte('1, 1'b0);
    wait_drained();

    // mode switch while a header is one flag byte short, then mid-payload
    push_tag_header();
    push_frame_head(id_pool[1], 32'd2, HeadBytes - 1);
    wait_drained();
    write_reg(CFG_TARGET, id_pool[1]);
    write_reg(CFG_MODE, MODE_GET);
    push_byte(ByteW'($urandom), 1'b0);
    push_byte(ByteW'($urandom), 1'b0);
    wait_drained();
    write_reg(CFG_MODE, MODE_SHOW);
    push_byte(ByteW'($urandom), 1'b0);
    push_frame(pick_id(), 32'd1, 1);
    push_byte('0, 1'b0);
    wait_drained();

    // get mode stop: frames after the match are not walked
    write_reg(CFG_TARGET, id_pool[2]);
    write_reg(CFG_MODE, MODE_GET);
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '1);
    push_tag_header();
    push_frame(id_pool[0], 32'd1, 1);
    push_frame(id_pool[2], 32'd2, 2);
    push_frame(id_pool[2], 32'd1, 1);
    push_byte('0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          m = MODE_SHOW;
          t = id_pool[0];
        end
        1: begin
          m = MODE_GET;
          t = '0;
        end
        2: begin
          m = MODE_GET;
          t = '1;
        end
        5: begin
          m = MODE_SHOW;
          t = $urandom;
        end
        default: begin
          m = $urandom_range(0, 1) ? MODE_GET : MODE_SHOW;
          t = id_pool[$urandom_range(0, 3)];
        end
      endcase
      write_reg(CFG_TARGET, t);
      write_reg(CFG_MODE, m);
      rx_style = (ph == 3) ? RX_ALWAYS : rx_style_e'($urandom_range(0, 3));
      tx_style = (ph == 3) ? TX_STEADY : tx_style_e'($urandom_range(0, 1));
      if (ph == 0 || ph == 5) hold_left = LongHold;
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        case ($urandom_range(0, 9))
          0, 1:    push_noise();
          2, 3:    push_broken_file();
          default: push_clean_file();
        endcase
      end
      wait_drained();
    end

    $display("summary: %0d bytes in %0d files, %0d register writes, show and get modes",
             n_bytes, n_files, n_writes);
    $display("summary: checked %0d headers, %0d payload bytes, %0d end markers",
             n_hdr, n_data, n_end);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
